// ----- rtl/lmts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_pkg
// Shared types, constants and the font ROM of the LED matrix text scroller.
// ----------------------------------------------------------------------------
package lmts_pkg;

  localparam int unsigned MaxCharsDef = 64;
  localparam int unsigned LenW        = 7;
  localparam int unsigned CodeW       = 8;
  localparam int unsigned OffW        = 10;
  localparam int unsigned RowW        = 3;
  localparam int unsigned RowAddrW    = 4;
  localparam int unsigned NumRows     = 8;
  localparam int unsigned CharStep    = 9;
  localparam int unsigned GlyphCols   = 8;
  // Reciprocal of nine in 12 fractional bits; the estimate is at most one low.
  localparam int unsigned RecipMul    = 455;
  localparam int unsigned RecipShift  = 12;
  localparam int unsigned RecipW      = 9;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_RENDER = 2'd2
  } cmd_e;

  typedef struct packed {
    logic load_offset;
    logic do_append;
    logic do_clear;
    logic div_mul;
    logic div_fix;
    logic rd_sel_b;
    logic ld_a;
    logic ld_b;
    logic row_clr;
    logic row_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic row_last;
  } dp_status_t;

  localparam logic [7:0] DIGIT_ROM [10][8] = '{
    '{8'h00, 8'h3C, 8'h66, 8'h66, 8'h6E, 8'h76, 8'h66, 8'h3C},
    '{8'h00, 8'h7E, 8'h18, 8'h18, 8'h18, 8'h18, 8'h1C, 8'h18},
    '{8'h00, 8'h7E, 8'h0C, 8'h18, 8'h30, 8'h60, 8'h66, 8'h3C},
    '{8'h00, 8'h3C, 8'h66, 8'h60, 8'h38, 8'h60, 8'h66, 8'h3C},
    '{8'h00, 8'h30, 8'h30, 8'h7E, 8'h36, 8'h3C, 8'h38, 8'h30},
    '{8'h00, 8'h3C, 8'h66, 8'h60, 8'h60, 8'h3E, 8'h06, 8'h7E},
    '{8'h00, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h3E, 8'h06, 8'h3C},
    '{8'h00, 8'h0C, 8'h0C, 8'h0C, 8'h18, 8'h30, 8'h60, 8'h7E},
    '{8'h00, 8'h3C, 8'h66, 8'h66, 8'h3C, 8'h66, 8'h66, 8'h3C},
    '{8'h00, 8'h3C, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h66, 8'h3C}
  };

  localparam logic [7:0] LETTER_ROM [26][8] = '{
    '{8'h00, 8'h66, 8'h66, 8'h7E, 8'h66, 8'h66, 8'h3C, 8'h18},
    '{8'h00, 8'h3E, 8'h66, 8'h66, 8'h3E, 8'h66, 8'h66, 8'h3E},
    '{8'h00, 8'h3C, 8'h66, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C},
    '{8'h00, 8'h1E, 8'h36, 8'h66, 8'h66, 8'h66, 8'h36, 8'h1E},
    '{8'h00, 8'h7E, 8'h06, 8'h06, 8'h3E, 8'h06, 8'h06, 8'h7E},
    '{8'h00, 8'h06, 8'h06, 8'h06, 8'h3E, 8'h06, 8'h06, 8'h7E},
    '{8'h00, 8'h3C, 8'h66, 8'h66, 8'h76, 8'h06, 8'h66, 8'h3C},
    '{8'h00, 8'h66, 8'h66, 8'h66, 8'h7E, 8'h66, 8'h66, 8'h66},
    '{8'h00, 8'h7E, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E},
    '{8'h00, 8'h1C, 8'h36, 8'h30, 8'h30, 8'h30, 8'h30, 8'h78},
    '{8'h00, 8'h66, 8'h36, 8'h1E, 8'h0E, 8'h1E, 8'h36, 8'h66},
    '{8'h00, 8'h7E, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06},
    '{8'h00, 8'hC6, 8'hC6, 8'hC6, 8'hD6, 8'hFE, 8'hEE, 8'hC6},
    '{8'h00, 8'h66, 8'h66, 8'h76, 8'h7E, 8'h7E, 8'h6E, 8'h66},
    '{8'h00, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
    '{8'h00, 8'h06, 8'h06, 8'h06, 8'h3E, 8'h66, 8'h66, 8'h3E},
    '{8'h00, 8'h6C, 8'h36, 8'h56, 8'h66, 8'h66, 8'h66, 8'h3C},
    '{8'h00, 8'h66, 8'h36, 8'h1E, 8'h3E, 8'h66, 8'h66, 8'h3E},
    '{8'h00, 8'h3C, 8'h66, 8'h60, 8'h3C, 8'h06, 8'h66, 8'h3C},
    '{8'h00, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E},
    '{8'h00, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66},
    '{8'h00, 8'h18, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66},
    '{8'h00, 8'hC6, 8'hEE, 8'hFE, 8'hD6, 8'hC6, 8'hC6, 8'hC6},
    '{8'h00, 8'h66, 8'h66, 8'h3C, 8'h18, 8'h3C, 8'h66, 8'h66},
    '{8'h00, 8'h18, 8'h18, 8'h18, 8'h3C, 8'h66, 8'h66, 8'h66},
    '{8'h00, 8'h7E, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'h7E}
  };

  // One row of the glyph for a character code. Lowercase shows as uppercase;
  // anything that is not a letter or a digit is blank.
  function automatic logic [7:0] glyph_row(input logic [CodeW-1:0] code,
                                           input logic [RowW-1:0]  row);
    logic [CodeW-1:0] up;
    logic [7:0]       res;
    up  = code;
    res = '0;
    if (code >= 8'h61 && code <= 8'h7A) begin
      up = code - 8'h20;
    end
    if (up >= 8'h41 && up <= 8'h5A) begin
      res = LETTER_ROM[5'(up - 8'h41)][row];
    end else if (up >= 8'h30 && up <= 8'h39) begin
      res = DIGIT_ROM[4'(up - 8'h30)][row];
    end
    return res;
  endfunction

endpackage

// ----- rtl/lmts_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_if
// Command and row-write channels of the LED matrix text scroller.
// ----------------------------------------------------------------------------
interface lmts_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [lmts_pkg::CodeW-1:0] char_code;
  logic [lmts_pkg::OffW-1:0]  scroll_offset;

  modport source (output valid, command, char_code, scroll_offset, input ready);
  modport sink   (input valid, command, char_code, scroll_offset, output ready);
endinterface

interface lmts_row_if;
  logic                          valid;
  logic                          ready;
  logic [lmts_pkg::RowAddrW-1:0] row_address;
  logic [7:0]                    row_data;
  logic                          last_row;

  modport source (output valid, row_address, row_data, last_row, input ready);
  modport sink   (input valid, row_address, row_data, last_row, output ready);
endinterface

// ----- rtl/led_matrix_text_scroller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_text_scroller
// Scrolling text renderer for an 8x8 LED matrix: text buffer plus row writer.
// ----------------------------------------------------------------------------
// Append and clear transactions produce no output. A render transaction
// produces eight row writes, addresses 1 to 8, row 0 first, the last
// flagged by last_row. After the command is taken, the setup steps split
// the window position into character and column by a reciprocal multiply
// and one correction, then make two reads of the text memory for the two
// characters that the window can touch; the rows then follow, one row
// write per cycle while the row channel does not stall. New commands are
// taken only once the eighth row write has been accepted. Each character
// is eight glyph columns and one blank column wide; a scroll offset of
// eight puts the first character at the left edge. Appends beyond
// MAX_CHARS are dropped.
// ----------------------------------------------------------------------------
module led_matrix_text_scroller #(
  parameter int unsigned MAX_CHARS = lmts_pkg::MaxCharsDef
) (
  input logic         clk_i,
  input logic         rst_ni,
  lmts_cmd_if.sink    cmd_i,
  lmts_row_if.source  row_o
);
  import lmts_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  lmts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (cmd_i.valid),
    .in_command_i (cmd_i.command),
    .in_ready_o   (cmd_i.ready),
    .out_valid_o  (row_o.valid),
    .out_ready_i  (row_o.ready),
    .dp_cmd_o     (dp_cmd),
    .dp_status_i  (dp_status)
  );

  lmts_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dp_cmd_i        (dp_cmd),
    .dp_status_o     (dp_status),
    .char_code_i     (cmd_i.char_code),
    .scroll_offset_i (cmd_i.scroll_offset),
    .row_address_o   (row_o.row_address),
    .row_data_o      (row_o.row_data),
    .last_row_o      (row_o.last_row)
  );

endmodule

// ----- rtl/lmts_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_ctrl
// Sequencer: takes commands, steps the datapath through a render, hands out
// the eight row writes.
// ----------------------------------------------------------------------------
module lmts_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_command_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lmts_pkg::dp_cmd_t    dp_cmd_o,
  input  lmts_pkg::dp_status_t dp_status_i
);
  import lmts_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_FIX  = 7'b0000100,
    ST_RDA  = 7'b0001000,
    ST_RDB  = 7'b0010000,
    ST_LDB  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    dp_cmd_o    = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.load_offset = 1'b1;
          if (in_command_i == CMD_APPEND) begin
            dp_cmd_o.do_append = 1'b1;
          end else if (in_command_i == CMD_CLEAR) begin
            dp_cmd_o.do_clear = 1'b1;
          end else if (in_command_i == CMD_RENDER) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        dp_cmd_o.div_mul = 1'b1;
        state_d          = ST_FIX;
      end
      ST_FIX: begin
        dp_cmd_o.div_fix = 1'b1;
        state_d          = ST_RDA;
      end
      ST_RDA: begin
        state_d = ST_RDB;
      end
      ST_RDB: begin
        dp_cmd_o.rd_sel_b = 1'b1;
        dp_cmd_o.ld_a     = 1'b1;
        state_d           = ST_LDB;
      end
      ST_LDB: begin
        dp_cmd_o.ld_b    = 1'b1;
        dp_cmd_o.row_clr = 1'b1;
        state_d          = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (dp_status_i.row_last) begin
            state_d = ST_IDLE;
          end else begin
            dp_cmd_o.row_inc = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Row output follows the load of the second character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LDB) |=> (state_q == ST_EMIT))
    else $error("Row output did not follow the second character load.");

  // The last row write returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && dp_status_i.row_last) |=> in_ready_o)
    else $error("Sequencer did not return to idle after the last row.");

  // No command is taken while a render is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Command and row channels were open together.");

endmodule

// ----- rtl/lmts_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_dp
// Datapath: text memory and length, column-to-character split by nine,
// character fetch and row composition.
// ----------------------------------------------------------------------------
module lmts_dp #(
  parameter int unsigned MAX_CHARS = lmts_pkg::MaxCharsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lmts_pkg::dp_cmd_t             dp_cmd_i,
  output lmts_pkg::dp_status_t          dp_status_o,
  input  logic [lmts_pkg::CodeW-1:0]    char_code_i,
  input  logic [lmts_pkg::OffW-1:0]     scroll_offset_i,
  output logic [lmts_pkg::RowAddrW-1:0] row_address_o,
  output logic [7:0]                    row_data_o,
  output logic                          last_row_o
);
  import lmts_pkg::*;

  localparam int unsigned AddrW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int unsigned VW    = OffW + 1;
  localparam int unsigned ProdW = VW + RecipW;

  logic [CodeW-1:0] mem [MAX_CHARS];
  logic [CodeW-1:0] rd_q;
  logic [AddrW-1:0] rd_addr;
  logic [LenW-1:0]  len_q;
  logic             full;

  // The window position is taken one column further on, so that the
  // columns before the text form a virtual character of index zero.
  logic [VW-1:0]    pos_q;
  logic [ProdW-1:0] prod;
  logic [LenW-1:0]  quot_q;
  logic [VW-1:0]    nine_q;
  logic [VW-1:0]    rem;
  logic [LenW-1:0]  kidx_q;
  logic [3:0]       col0_q;
  logic [LenW-1:0]  kidx_m1;

  logic [CodeW-1:0] code_a_q, code_b_q;
  logic [RowW-1:0]  row_q;
  logic             valid_a, valid_b;
  logic [7:0]       glyph_a, glyph_b;

  assign full = (len_q == LenW'(MAX_CHARS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (dp_cmd_i.do_clear) begin
      len_q <= '0;
    end else if (dp_cmd_i.do_append && !full) begin
      len_q <= len_q + LenW'(1);
    end
  end

  assign kidx_m1 = kidx_q - LenW'(1);
  assign rd_addr = dp_cmd_i.rd_sel_b ? kidx_q[AddrW-1:0] : kidx_m1[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.do_append && !full) begin
      mem[len_q[AddrW-1:0]] <= char_code_i;
    end
    rd_q <= mem[rd_addr];
  end

  assign prod   = ProdW'(pos_q) * ProdW'(RecipMul);
  assign nine_q = VW'({quot_q, 3'b000}) + VW'(quot_q);
  assign rem    = pos_q - nine_q;

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load_offset) begin
      pos_q <= VW'(scroll_offset_i) + VW'(1);
    end
    if (dp_cmd_i.div_mul) begin
      quot_q <= prod[RecipShift +: LenW];
    end
    if (dp_cmd_i.div_fix) begin
      if (rem >= VW'(CharStep)) begin
        kidx_q <= quot_q + LenW'(1);
        col0_q <= 4'(rem - VW'(CharStep));
      end else begin
        kidx_q <= quot_q;
        col0_q <= 4'(rem);
      end
    end
    if (dp_cmd_i.ld_a) begin
      code_a_q <= rd_q;
    end
    if (dp_cmd_i.ld_b) begin
      code_b_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (dp_cmd_i.row_clr) begin
      row_q <= '0;
    end else if (dp_cmd_i.row_inc) begin
      row_q <= row_q + RowW'(1);
    end
  end

  // The window covers the tail of character A and the head of character B.
  assign valid_a = (kidx_q != '0) && (kidx_q <= len_q);
  assign valid_b = (kidx_q < len_q);
  assign glyph_a = glyph_row(code_a_q, row_q);
  assign glyph_b = glyph_row(code_b_q, row_q);

  always_comb begin
    logic [4:0] s;
    logic [4:0] sb;
    row_data_o = '0;
    for (int c = 0; c < GlyphCols; c++) begin
      s  = 5'(col0_q) + 5'(c);
      sb = s - 5'(CharStep);
      if (s < 5'(CharStep)) begin
        row_data_o[c] = valid_a && (s != 5'(GlyphCols)) && glyph_a[s[2:0]];
      end else begin
        row_data_o[c] = valid_b && glyph_b[sb[2:0]];
      end
    end
  end

  assign row_address_o        = RowAddrW'(row_q) + RowAddrW'(1);
  assign last_row_o           = (row_q == RowW'(NumRows - 1));
  assign dp_status_o.row_last = last_row_o;

  // The stored length never runs past the buffer size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MAX_CHARS))
    else $error("Text length exceeds the buffer size.");

  // An append into a buffer with room grows the text by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd_i.do_append && !full && !dp_cmd_i.do_clear)
      |=> (len_q == $past(len_q) + LenW'(1)))
    else $error("Append did not grow the text by one character.");

  // The split by nine leaves a column within one character step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(dp_cmd_i.div_fix) |-> (col0_q < 4'(CharStep)))
    else $error("Column within character out of range.");

endmodule
